FILE: rtl/core/sra_pkg.sv
// Shared types and constants of the skyline rectangle allocator.
package sra_pkg;

    localparam int REQ_BITS  = 12;
    localparam int CFG_BITS  = 13;
    localparam int AREA_BITS = 25;
    localparam int PROD_BITS = 2 * REQ_BITS;

    // Configuration register indexes.
    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    // Request commands.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } rsp_status_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLEAR, S_CAND, S_CAND_CHK, S_WALK_RD, S_WALK_CHK,
        S_DECIDE, S_INS_RD, S_INS_WR, S_TRIM_RD, S_TRIM_CHK, S_RM_RD, S_RM_WR,
        S_MERGE_RD, S_MERGE_RD2, S_MERGE_CHK, S_AREA, S_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_INIT, OP_LOAD, OP_CLEAR, OP_CAND_RD, OP_CAND_CHK, OP_WALK_RD,
        OP_WALK_CHK, OP_DECIDE, OP_INS_RD, OP_INS_WR, OP_TRIM_RD, OP_TRIM_CHK,
        OP_RM_RD, OP_RM_WR, OP_MERGE_RD, OP_MERGE_RD2, OP_MERGE_CHK, OP_AREA,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic cand_end;
        logic cand_done;
        logic walk_oob;
        logic walk_done;
        logic found;
        logic full;
        logic ins_more;
        logic trim_more;
        logic trim_remove;
        logic rm_more;
        logic merge_more;
        logic merge_eq;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/sra_ctrl.sv
// Sequencing state machine of the skyline rectangle allocator.
module sra_ctrl import sra_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_command,
    output logic       s_ready,
    input  dp_status_t stat,
    output dp_op_t     op
);

    ctrl_state_t state_reg, state_next;
    logic        ret_merge_reg, ret_merge_next;

    // State and return-path registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            ret_merge_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_merge_reg <= ret_merge_next;
        end
    end

    // Next state.
    always_comb begin
        state_next     = state_reg;
        ret_merge_next = ret_merge_reg;
        unique case (state_reg)
            S_INIT:      state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_command == CMD_CLEAR) ? S_CLEAR : S_CAND;
                end
            end
            S_CLEAR:     state_next = S_DONE;
            S_CAND:      state_next = stat.cand_end ? S_DECIDE : S_CAND_CHK;
            S_CAND_CHK:  state_next = stat.cand_done ? S_CAND : S_WALK_RD;
            S_WALK_RD:   state_next = stat.walk_oob ? S_CAND : S_WALK_CHK;
            S_WALK_CHK:  state_next = stat.walk_done ? S_CAND : S_WALK_RD;
            S_DECIDE:    state_next = (!stat.found || stat.full) ? S_DONE : S_INS_RD;
            S_INS_RD:    state_next = stat.ins_more ? S_INS_WR : S_TRIM_RD;
            S_INS_WR:    state_next = S_INS_RD;
            S_TRIM_RD:   state_next = stat.trim_more ? S_TRIM_CHK : S_MERGE_RD;
            S_TRIM_CHK: begin
                ret_merge_next = 1'b0;
                state_next     = stat.trim_remove ? S_RM_RD : S_MERGE_RD;
            end
            S_RM_RD: begin
                if (stat.rm_more) begin
                    state_next = S_RM_WR;
                end else begin
                    state_next = ret_merge_reg ? S_MERGE_RD : S_TRIM_RD;
                end
            end
            S_RM_WR:     state_next = S_RM_RD;
            S_MERGE_RD:  state_next = stat.merge_more ? S_MERGE_RD2 : S_AREA;
            S_MERGE_RD2: state_next = S_MERGE_CHK;
            S_MERGE_CHK: begin
                ret_merge_next = 1'b1;
                state_next     = stat.merge_eq ? S_RM_RD : S_MERGE_RD;
            end
            S_AREA:      state_next = S_DONE;
            S_DONE:      state_next = stat.out_free ? S_IDLE : S_DONE;
            default:     state_next = S_INIT;
        endcase
    end

    // Datapath command and handshake.
    always_comb begin
        s_ready = 1'b0;
        op      = OP_NOP;
        unique case (state_reg)
            S_INIT:      op = OP_INIT;
            S_IDLE: begin
                s_ready = 1'b1;
                op      = s_valid ? OP_LOAD : OP_NOP;
            end
            S_CLEAR:     op = OP_CLEAR;
            S_CAND:      op = OP_CAND_RD;
            S_CAND_CHK:  op = OP_CAND_CHK;
            S_WALK_RD:   op = OP_WALK_RD;
            S_WALK_CHK:  op = OP_WALK_CHK;
            S_DECIDE:    op = OP_DECIDE;
            S_INS_RD:    op = OP_INS_RD;
            S_INS_WR:    op = OP_INS_WR;
            S_TRIM_RD:   op = OP_TRIM_RD;
            S_TRIM_CHK:  op = OP_TRIM_CHK;
            S_RM_RD:     op = OP_RM_RD;
            S_RM_WR:     op = OP_RM_WR;
            S_MERGE_RD:  op = OP_MERGE_RD;
            S_MERGE_RD2: op = OP_MERGE_RD2;
            S_MERGE_CHK: op = OP_MERGE_CHK;
            S_AREA:      op = OP_AREA;
            S_DONE:      op = stat.out_free ? OP_EMIT : OP_NOP;
            default:     op = OP_NOP;
        endcase
    end

endmodule

FILE: rtl/core/sra_dp.sv
// Segment table memory, fit arithmetic and result registers of the allocator.
module sra_dp import sra_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_op_t               op,
    output dp_status_t           stat,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_wdata,
    input  logic [REQ_BITS-1:0]  s_req_width,
    input  logic [REQ_BITS-1:0]  s_req_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [REQ_BITS-1:0]  m_region_x,
    output logic [REQ_BITS-1:0]  m_region_y,
    output logic [AREA_BITS-1:0] m_used_area
);

    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW  = IW + 1;
    localparam int CW  = COORD_BITS;
    localparam int SW  = ((CW > REQ_BITS) ? CW : REQ_BITS) + 1;
    localparam int EW  = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
    localparam int RST_DIM = (512 > (1 << CW)) ? (1 << CW) : 512;
    localparam logic [CW-1:0] RST_W = CW'(RST_DIM - 2);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SEGMENTS);
    localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
    } seg_t;

    seg_t mem [MAX_SEGMENTS];
    seg_t rd_reg, hold_reg, hold_next;
    seg_t wdata;
    logic [IW-1:0] waddr, raddr;
    logic we, rd_en;

    logic [NW-1:0] cnt_reg, cnt_next, cand_reg, cand_next, j_reg, j_next;
    logic [NW-1:0] k_reg, k_next, ti_reg, ti_next, mi_reg, mi_next;
    logic [NW-1:0] best_reg, best_next;
    logic [CW-1:0] y_reg, y_next, cx_reg, cx_next, cw_reg, cw_next;
    logic [CW-1:0] bw_reg, bw_next, bx_reg, bx_next, by_reg, by_next;
    logic [REQ_BITS-1:0] left_reg, left_next, rw_reg, rw_next, rh_reg, rh_next;
    logic [SW-1:0] top_reg, top_next, endp_reg, endp_next;
    logic found_reg, found_next;
    logic [PROD_BITS-1:0] prod_reg;
    logic [AREA_BITS-1:0] area_reg, area_next;
    rsp_status_t res_st_reg, res_st_next;
    logic [REQ_BITS-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [CFG_BITS-1:0] aw_reg, ah_reg;
    logic out_v_reg, out_v_next;
    logic [1:0] out_st_reg;
    logic [REQ_BITS-1:0] out_x_reg, out_y_reg;
    logic [AREA_BITS-1:0] out_a_reg;

    // Clamped atlas limits.
    logic [EW-1:0] aw_e, ah_e, aw_c, ah_c, top_dim;
    logic [SW-1:0] wlim, hlim;
    logic [CW-1:0] clear_w;

    always_comb begin
        top_dim = EW'(1) << CW;
        aw_e    = EW'(aw_reg);
        ah_e    = EW'(ah_reg);
        aw_c    = (aw_e < EW'(3)) ? EW'(3) : ((aw_e > top_dim) ? top_dim : aw_e);
        ah_c    = (ah_e < EW'(3)) ? EW'(3) : ((ah_e > top_dim) ? top_dim : ah_e);
        wlim    = SW'(aw_c - EW'(1));
        hlim    = SW'(ah_c - EW'(1));
        clear_w = CW'(aw_c - EW'(2));
    end

    // Fit, trim and merge tests on the entry just read.
    logic [SW-1:0] rx, ry, rwid, reqw, reqh, ymax, row, top, kk, lft;
    logic [CW-1:0] bw_cand;
    logic chk_fail, chk_succ, walk_fail, walk_succ, better, trim_over;
    logic [REQ_BITS-1:0] left_dec;
    logic [AREA_BITS:0] area_sum;

    always_comb begin
        rx        = SW'(rd_reg.x);
        ry        = SW'(rd_reg.y);
        rwid      = SW'(rd_reg.w);
        reqw      = SW'(rw_reg);
        reqh      = SW'(rh_reg);
        lft       = SW'(left_reg);
        chk_fail  = (rx + reqw > wlim) || (ry + reqh > hlim);
        chk_succ  = !chk_fail && (rw_reg == '0);
        ymax      = (ry > SW'(y_reg)) ? ry : SW'(y_reg);
        walk_fail = (ymax + reqh > hlim);
        left_dec  = (lft > rwid) ? REQ_BITS'(lft - rwid) : '0;
        walk_succ = !walk_fail && (left_dec == '0);
        row       = (op == OP_CAND_CHK) ? ry : ymax;
        bw_cand   = (op == OP_CAND_CHK) ? rd_reg.w : cw_reg;
        top       = row + reqh;
        better    = !found_reg || (top < top_reg) ||
                    ((top == top_reg) && (bw_cand < bw_reg));
        trim_over = (rx < endp_reg);
        kk        = endp_reg - rx;
        area_sum  = (AREA_BITS + 1)'(area_reg) + (AREA_BITS + 1)'(prod_reg);
    end

    always_comb begin
        stat.cand_end    = (cand_reg >= cnt_reg);
        stat.cand_done   = chk_fail || chk_succ;
        stat.walk_oob    = (j_reg >= cnt_reg);
        stat.walk_done   = walk_fail || walk_succ;
        stat.found       = found_reg;
        stat.full        = (cnt_reg >= MAX_N);
        stat.ins_more    = (k_reg > best_reg);
        stat.trim_more   = (ti_reg < cnt_reg);
        stat.trim_remove = trim_over && (rwid <= kk);
        stat.rm_more     = (k_reg + NW'(1) < cnt_reg);
        stat.merge_more  = (mi_reg + NW'(1) < cnt_reg);
        stat.merge_eq    = (hold_reg.y == rd_reg.y);
        stat.out_free    = !out_v_reg || m_ready;
    end

    // Operation decode: next values, memory read and write.
    always_comb begin
        cnt_next = cnt_reg;   cand_next = cand_reg;  j_next = j_reg;
        k_next = k_reg;       ti_next = ti_reg;      mi_next = mi_reg;
        best_next = best_reg; y_next = y_reg;        cx_next = cx_reg;
        cw_next = cw_reg;     bw_next = bw_reg;      bx_next = bx_reg;
        by_next = by_reg;     left_next = left_reg;  rw_next = rw_reg;
        rh_next = rh_reg;     top_next = top_reg;    endp_next = endp_reg;
        found_next = found_reg; area_next = area_reg; hold_next = hold_reg;
        res_st_next = res_st_reg; res_x_next = res_x_reg; res_y_next = res_y_reg;
        out_v_next = out_v_reg && !m_ready;
        we = 1'b0; waddr = '0; wdata = rd_reg; rd_en = 1'b0; raddr = '0;
        unique case (op)
            OP_NOP: ;
            OP_INIT: begin
                we = 1'b1; wdata = '{x: ONE_C, y: ONE_C, w: RST_W};
                cnt_next = NW'(1); area_next = '0;
            end
            OP_LOAD: begin
                rw_next = s_req_width; rh_next = s_req_height;
                cand_next = '0; found_next = 1'b0;
            end
            OP_CLEAR: begin
                we = 1'b1; wdata = '{x: ONE_C, y: ONE_C, w: clear_w};
                cnt_next = NW'(1); area_next = '0;
                res_st_next = ST_OK; res_x_next = '0; res_y_next = '0;
            end
            OP_CAND_RD: begin
                rd_en = 1'b1; raddr = cand_reg[IW-1:0]; j_next = cand_reg;
            end
            OP_CAND_CHK: begin
                if (chk_fail || chk_succ) begin
                    cand_next = cand_reg + NW'(1);
                end else begin
                    cx_next = rd_reg.x; cw_next = rd_reg.w;
                    y_next = rd_reg.y;  left_next = rw_reg;
                end
            end
            OP_WALK_RD: begin
                if (j_reg >= cnt_reg) begin
                    cand_next = cand_reg + NW'(1);
                end else begin
                    rd_en = 1'b1; raddr = j_reg[IW-1:0];
                end
            end
            OP_WALK_CHK: begin
                y_next = CW'(ymax); left_next = left_dec; j_next = j_reg + NW'(1);
                if (walk_fail || walk_succ) begin
                    cand_next = cand_reg + NW'(1);
                end
            end
            OP_DECIDE: begin
                res_x_next = '0; res_y_next = '0;
                k_next = cnt_reg; mi_next = '0;
                if (!found_reg) begin
                    res_st_next = ST_NOFIT;
                end else if (cnt_reg >= MAX_N) begin
                    res_st_next = ST_FULL;
                end
            end
            OP_INS_RD: begin
                if (k_reg > best_reg) begin
                    rd_en = 1'b1; raddr = IW'(k_reg - NW'(1));
                end else begin
                    we = 1'b1; waddr = best_reg[IW-1:0];
                    wdata = '{x: bx_reg, y: CW'(SW'(by_reg) + reqh), w: CW'(rw_reg)};
                    cnt_next = cnt_reg + NW'(1);
                    ti_next = best_reg + NW'(1);
                    endp_next = SW'(bx_reg) + reqw;
                end
            end
            OP_INS_WR: begin
                we = 1'b1; waddr = k_reg[IW-1:0]; k_next = k_reg - NW'(1);
            end
            OP_TRIM_RD: begin
                rd_en = 1'b1; raddr = ti_reg[IW-1:0];
            end
            OP_TRIM_CHK: begin
                if (trim_over && (rwid <= kk)) begin
                    k_next = ti_reg;
                end else if (trim_over) begin
                    we = 1'b1; waddr = ti_reg[IW-1:0];
                    wdata = '{x: CW'(endp_reg), y: rd_reg.y, w: CW'(rwid - kk)};
                end
            end
            OP_RM_RD: begin
                if (k_reg + NW'(1) < cnt_reg) begin
                    rd_en = 1'b1; raddr = IW'(k_reg + NW'(1));
                end else begin
                    cnt_next = cnt_reg - NW'(1);
                end
            end
            OP_RM_WR: begin
                we = 1'b1; waddr = k_reg[IW-1:0]; k_next = k_reg + NW'(1);
            end
            OP_MERGE_RD: begin
                rd_en = 1'b1; raddr = mi_reg[IW-1:0];
            end
            OP_MERGE_RD2: begin
                hold_next = rd_reg; rd_en = 1'b1; raddr = IW'(mi_reg + NW'(1));
            end
            OP_MERGE_CHK: begin
                if (hold_reg.y == rd_reg.y) begin
                    we = 1'b1; waddr = mi_reg[IW-1:0];
                    wdata = '{x: hold_reg.x, y: hold_reg.y, w: hold_reg.w + rd_reg.w};
                    k_next = mi_reg + NW'(1);
                end else begin
                    mi_next = mi_reg + NW'(1);
                end
            end
            OP_AREA: begin
                area_next = (area_sum > (AREA_BITS + 1)'(AREA_MAX)) ?
                            AREA_MAX : AREA_BITS'(area_sum);
                res_st_next = ST_OK;
                res_x_next = REQ_BITS'(SW'(bx_reg));
                res_y_next = REQ_BITS'(SW'(by_reg));
            end
            OP_EMIT: out_v_next = 1'b1;
            default: ;
        endcase

        // Keep the best candidate seen so far.
        if ((op == OP_CAND_CHK && chk_succ && better) ||
            (op == OP_WALK_CHK && walk_succ && better)) begin
            found_next = 1'b1;
            best_next  = cand_reg;
            top_next   = top;
            bw_next    = bw_cand;
            bx_next    = (op == OP_CAND_CHK) ? rd_reg.x : cx_reg;
            by_next    = CW'(row);
        end
    end

    // Segment table memory with registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_reg <= mem[raddr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= NW'(1);
            area_reg  <= '0;
            found_reg <= 1'b0;
            out_v_reg <= 1'b0;
            aw_reg    <= CFG_BITS'(512);
            ah_reg    <= CFG_BITS'(512);
        end else begin
            cnt_reg   <= cnt_next;
            area_reg  <= area_next;
            found_reg <= found_next;
            out_v_reg <= out_v_next;
            if (cfg_we && cfg_index == CFG_ATLAS_WIDTH) begin
                aw_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_ATLAS_HEIGHT) begin
                ah_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;  j_reg <= j_next;      k_reg <= k_next;
        ti_reg <= ti_next;      mi_reg <= mi_next;    best_reg <= best_next;
        y_reg <= y_next;        cx_reg <= cx_next;    cw_reg <= cw_next;
        bw_reg <= bw_next;      bx_reg <= bx_next;    by_reg <= by_next;
        left_reg <= left_next;  rw_reg <= rw_next;    rh_reg <= rh_next;
        top_reg <= top_next;    endp_reg <= endp_next; hold_reg <= hold_next;
        res_st_reg <= res_st_next; res_x_reg <= res_x_next; res_y_reg <= res_y_next;
        prod_reg <= rw_reg * rh_reg;
        if (op == OP_EMIT) begin
            out_st_reg <= res_st_reg;
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
            out_a_reg  <= area_reg;
        end
    end

    assign m_valid     = out_v_reg;
    assign m_status    = out_st_reg;
    assign m_region_x  = out_x_reg;
    assign m_region_y  = out_y_reg;
    assign m_used_area = out_a_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg >= NW'(1)) && (cnt_reg <= MAX_N))
        else $error("segment count out of range");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + NW'(1)) ||
                 (cnt_reg == $past(cnt_reg) - NW'(1)) || (cnt_reg == NW'(1)))
        else $error("segment count jumped");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_EMIT) |=> out_v_reg)
        else $error("result lost at emit");
`endif

endmodule

FILE: rtl/core/skyline_rect_allocator.sv
// Top level of the skyline rectangle allocator.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    command, req_width, req_height
//  m_        out        m_valid/m_ready    status, region_x, region_y, used_area
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One request at a time; a clear writes the initial segment. An allocation tests each candidate,
// walks the segments of each fit test, moves entries for an insert or a removal, and runs
// trim and merge tests; every step goes through the single read port of the segment table.
// After reset the block writes the initial segment before it takes the first request.
// A finished result waits in the output register while the next request is taken.
module skyline_rect_allocator import sra_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [REQ_BITS-1:0]  s_req_width,
    input  logic [REQ_BITS-1:0]  s_req_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [REQ_BITS-1:0]  m_region_x,
    output logic [REQ_BITS-1:0]  m_region_y,
    output logic [AREA_BITS-1:0] m_used_area
);

    dp_op_t     op;
    dp_status_t stat;

    sra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .op        (op)
    );

    sra_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_req_width  (s_req_width),
        .s_req_height (s_req_height),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_region_x   (m_region_x),
        .m_region_y   (m_region_y),
        .m_used_area  (m_used_area)
    );

endmodule

FILE: tb/sv/skyline_rect_allocator_test.sv
// Self-checking bench for the skyline rectangle allocator, with a built-in packing predictor.
module skyline_rect_allocator_test;
    import sra_pkg::*;

    localparam int NSEG = 64;
    localparam int CBITS = 12;
    localparam int RANDOM_REQUESTS = 600;

    typedef struct packed {
        logic            command;
        logic [11:0]     width;
        logic [11:0]     height;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [11:0]     x;
        logic [11:0]     y;
        logic [24:0]     area;
    } alloc_rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = 1'b0;
    logic [11:0] s_req_width = '0;
    logic [11:0] s_req_height = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic [11:0] m_region_x;
    logic [11:0] m_region_y;
    logic [24:0] m_used_area;

    skyline_rect_allocator #(.MAX_SEGMENTS(NSEG), .COORD_BITS(CBITS)) dut (.*);

    always #4 aclk = ~aclk;

    // Predictor state: the skyline as the block should hold it.
    int unsigned sky_x[NSEG];
    int unsigned sky_y[NSEG];
    int unsigned sky_w[NSEG];
    int unsigned sky_n;
    int unsigned placed_area;
    int unsigned atlas_w_reg;
    int unsigned atlas_h_reg;

    alloc_req_t pending_reqs[$];
    alloc_rsp_t expected_rsps[$];
    int error_count = 0;
    int rsp_count = 0;
    int placed_count = 0;
    int nofit_count = 0;
    int full_count = 0;
    bit quiet_stretch = 1'b0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 3) return 3;
        if (v > (1 << CBITS)) return 1 << CBITS;
        return v;
    endfunction

    function automatic void sky_clear();
        for (int k = 0; k < NSEG; k++) begin
            sky_x[k] = 0;
            sky_y[k] = 0;
            sky_w[k] = 0;
        end
        sky_x[0] = 1;
        sky_y[0] = 1;
        sky_w[0] = clamp_dim(atlas_w_reg) - 2;
        sky_n = 1;
        placed_area = 0;
    endfunction

    // Row at which a w by h rectangle rests when its left edge sits on segment idx.
    function automatic bit sky_fit(int unsigned idx, int unsigned w, int unsigned h,
                                   output int unsigned row);
        int unsigned wlim, hlim, y, left, i;
        wlim = clamp_dim(atlas_w_reg) - 1;
        hlim = clamp_dim(atlas_h_reg) - 1;
        row = 0;
        if (sky_x[idx] + w > wlim) return 0;
        y = sky_y[idx];
        if (y + h > hlim) return 0;
        left = w;
        i = idx;
        while (left > 0) begin
            if (i >= sky_n) return 0;
            if (sky_y[i] > y) y = sky_y[i];
            if (y + h > hlim) return 0;
            left = (left > sky_w[i]) ? left - sky_w[i] : 0;
            i++;
        end
        row = y;
        return 1;
    endfunction

    function automatic void sky_remove(int unsigned i);
        for (int unsigned k = i; k + 1 < sky_n; k++) begin
            sky_x[k] = sky_x[k + 1];
            sky_y[k] = sky_y[k + 1];
            sky_w[k] = sky_w[k + 1];
        end
        sky_n--;
    endfunction

    function automatic alloc_rsp_t predict_placement(alloc_req_t r);
        alloc_rsp_t rsp;
        int unsigned best, best_top, best_w, bx, by, row, top, i, fin, k, w, h;
        bit found;
        rsp = '0;
        found = 0;
        best = 0; best_top = 0; best_w = 0; bx = 0; by = 0;
        w = 32'(r.width);
        h = 32'(r.height);
        if (r.command == CMD_CLEAR) begin
            sky_clear();
            rsp.status = ST_OK;
            return rsp;
        end
        for (i = 0; i < sky_n; i++) begin
            if (sky_fit(i, w, h, row)) begin
                top = row + h;
                if (!found || top < best_top || (top == best_top && sky_w[i] < best_w)) begin
                    found = 1;
                    best = i;
                    best_top = top;
                    best_w = sky_w[i];
                    bx = sky_x[i];
                    by = row;
                end
            end
        end
        rsp.area = placed_area[24:0];
        if (!found) begin
            rsp.status = ST_NOFIT;
            return rsp;
        end
        if (sky_n >= NSEG) begin
            rsp.status = ST_FULL;
            return rsp;
        end
        // Insert the new top edge, shifting the rest up.
        for (k = sky_n; k > best; k--) begin
            sky_x[k] = sky_x[k - 1];
            sky_y[k] = sky_y[k - 1];
            sky_w[k] = sky_w[k - 1];
        end
        sky_x[best] = bx;
        sky_y[best] = by + h;
        sky_w[best] = w;
        sky_n++;
        // Trim or drop the segments now covered.
        i = best + 1;
        while (i < sky_n) begin
            fin = sky_x[i - 1] + sky_w[i - 1];
            if (sky_x[i] < fin) begin
                k = fin - sky_x[i];
                if (sky_w[i] <= k) sky_remove(i);
                else begin
                    sky_x[i] += k;
                    sky_w[i] -= k;
                    break;
                end
            end else break;
        end
        // Merge neighbours of equal height.
        i = 0;
        while (i + 1 < sky_n) begin
            if (sky_y[i] == sky_y[i + 1]) begin
                sky_w[i] += sky_w[i + 1];
                sky_remove(i + 1);
            end else i++;
        end
        placed_area += w * h;
        if (placed_area > 32'h1FFFFFF) placed_area = 32'h1FFFFFF;
        rsp.status = ST_OK;
        rsp.x = bx[11:0];
        rsp.y = by[11:0];
        rsp.area = placed_area[24:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH response %0d %s: got %0d, expected %0d", rsp_count, what, got, want);
        error_count++;
    endtask

    // Acceptance seen at the last rising edge.
    logic s_ready_seen = 1'b0;
    always @(posedge aclk) s_ready_seen <= s_valid && s_ready && aresetn;

    // Request driver: presents queued requests at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pending_reqs.size() > 0 && (quiet_stretch || $urandom_range(99) >= 10)) begin
                alloc_req_t r;
                r = pending_reqs.pop_front();
                expected_rsps.insert(expected_rsps.size(), predict_placement(r));
                s_valid <= 1'b1;
                s_command <= r.command;
                s_req_width <= r.width;
                s_req_height <= r.height;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= quiet_stretch || ($urandom_range(99) >= 10);
    end

    // Response monitor: checks each accepted response against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            alloc_rsp_t want;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response, status", 32'(m_status), 0);
            end else begin
                want = expected_rsps.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_region_x !== want.x)
                    report_mismatch("region_x", 32'(m_region_x), 32'(want.x));
                if (m_region_y !== want.y)
                    report_mismatch("region_y", 32'(m_region_y), 32'(want.y));
                if (m_used_area !== want.area)
                    report_mismatch("used_area", 32'(m_used_area), 32'(want.area));
                case (want.status)
                    ST_OK:    placed_count++;
                    ST_NOFIT: nofit_count++;
                    default:  full_count++;
                endcase
            end
            rsp_count++;
        end
    end

    function automatic alloc_req_t mk_req(logic c, int unsigned w, int unsigned h);
        alloc_req_t r;
        r.command = c;
        r.width = w[11:0];
        r.height = h[11:0];
        return r;
    endfunction

    // Appends a request to the end of the pending queue.
    function automatic void add_req(alloc_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[CFG_BITS-1:0];
        if (idx == CFG_ATLAS_WIDTH) atlas_w_reg = v & 16'h1FFF;
        else atlas_h_reg = v & 16'h1FFF;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small rectangles so the skyline grows many segments; some large and zero sizes, and some clears.
    function automatic alloc_req_t rand_req(int unsigned span);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 3) return mk_req(CMD_CLEAR, $urandom, $urandom);
        if (sel < 8) return mk_req(CMD_ALLOC, $urandom_range(4095), $urandom_range(4095));
        if (sel < 11) return mk_req(CMD_ALLOC, 0, $urandom_range(span));
        if (sel < 13) return mk_req(CMD_ALLOC, $urandom_range(span), 0);
        return mk_req(CMD_ALLOC, $urandom_range(1, span), $urandom_range(1, span));
    endfunction

    initial begin
        atlas_w_reg = 512;
        atlas_h_reg = 512;
        sky_clear();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, zero sizes, exact fill, no fit, clear.
        add_req(mk_req(CMD_ALLOC, 0, 0));
        add_req(mk_req(CMD_ALLOC, 10, 0));
        add_req(mk_req(CMD_ALLOC, 0, 10));
        add_req(mk_req(CMD_ALLOC, 4095, 4095));
        add_req(mk_req(CMD_ALLOC, 511, 1));
        add_req(mk_req(CMD_ALLOC, 510, 1));
        add_req(mk_req(CMD_ALLOC, 100, 50));
        add_req(mk_req(CMD_ALLOC, 100, 60));
        add_req(mk_req(CMD_ALLOC, 50, 50));
        add_req(mk_req(CMD_ALLOC, 260, 40));
        add_req(mk_req(CMD_ALLOC, 1, 509));
        add_req(mk_req(CMD_CLEAR, 4095, 4095));
        add_req(mk_req(CMD_ALLOC, 510, 510));
        add_req(mk_req(CMD_ALLOC, 1, 1));
        add_req(mk_req(CMD_CLEAR, 0, 0));
        // Many one-pixel columns of differing height fill the segment table.
        for (int k = 0; k < 70; k++) add_req(mk_req(CMD_ALLOC, 1, k % 2 + 1));
        wait_idle();

        // Largest atlas for the widest area figures, then the clamped extremes.
        write_reg(CFG_ATLAS_WIDTH, 8191);
        write_reg(CFG_ATLAS_HEIGHT, 4096);
        add_req(mk_req(CMD_ALLOC, 5, 5));
        add_req(mk_req(CMD_CLEAR, 0, 0));
        for (int k = 0; k < 4; k++) add_req(mk_req(CMD_ALLOC, 4094, 1023));
        add_req(mk_req(CMD_ALLOC, 1, 1));
        wait_idle();
        write_reg(CFG_ATLAS_WIDTH, 0);
        write_reg(CFG_ATLAS_HEIGHT, 2);
        add_req(mk_req(CMD_CLEAR, 0, 0));
        add_req(mk_req(CMD_ALLOC, 1, 1));
        add_req(mk_req(CMD_ALLOC, 1, 1));
        add_req(mk_req(CMD_ALLOC, 0, 0));
        wait_idle();

        // Random phases over several atlas shapes.
        for (int ph = 0; ph < 5; ph++) begin
            int unsigned aw, ah, span;
            case (ph)
                0: begin aw = 512;  ah = 512; end
                1: begin aw = 64;   ah = 48; end
                2: begin aw = 4096; ah = 300; end
                3: begin aw = 3;    ah = 4096; end
                default: begin aw = $urandom_range(3, 8191); ah = $urandom_range(3, 8191); end
            endcase
            write_reg(CFG_ATLAS_WIDTH, aw);
            write_reg(CFG_ATLAS_HEIGHT, ah);
            span = (clamp_dim(aw) < 64) ? clamp_dim(aw) : clamp_dim(aw) / 8;
            add_req(mk_req(CMD_CLEAR, 0, 0));
            quiet_stretch = (ph == 2);
            for (int k = 0; k < RANDOM_REQUESTS / 5; k++) add_req(rand_req(span));
            wait_idle();
            quiet_stretch = 1'b0;
        end

        $display("Checked %0d responses: %0d placed or cleared, %0d no fit, %0d table full.",
                 rsp_count, placed_count, nofit_count, full_count);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000000;
        $display("Timeout with %0d responses outstanding", expected_rsps.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
